### hw/rtl/gha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

	localparam int INDEX_BITS   = 10;
	localparam int VERSION_BITS = 8;
	localparam int SLOT_COUNT   = 1 << INDEX_BITS;

	typedef logic [INDEX_BITS-1:0]   index_t;
	typedef logic [VERSION_BITS-1:0] version_t;

	// Reserved list terminator: never handed out
	localparam index_t NULL_INDEX = {INDEX_BITS{1'b1}};

	typedef enum logic [1:0] {
		OP_CREATE   = 2'd0,
		OP_RELEASE  = 2'd1,
		OP_VALIDATE = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK            = 2'd0,
		ST_FULL          = 2'd1,
		ST_NEVER_CREATED = 2'd2,
		ST_UNUSED        = 2'd3
	} status_t;

	typedef struct packed {
		op_t      operation;
		index_t   entity_index;
		version_t entity_version;
	} req_t;

	typedef struct packed {
		index_t   result_index;
		version_t result_version;
		logic     is_valid;
		status_t  status;
	} rsp_t;

	// One slot: next free index (or own index while live) plus version
	typedef struct packed {
		index_t   idx;
		version_t ver;
	} slot_t;

	// Write port of the slot table
	typedef struct packed {
		logic   en;
		index_t addr;
		slot_t  data;
	} slot_wr_t;

endpackage

### hw/rtl/gha_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_slot_ram
// Slot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gha_slot_ram (
	input  logic              clk,
	input  logic              rd_en,
	input  gha_pkg::index_t   rd_addr,
	output gha_pkg::slot_t    rd_data,
	input  gha_pkg::slot_wr_t wr
);
	import gha_pkg::*;

	slot_t mem [SLOT_COUNT];
	slot_t rd_data_q;

	// Write the modified entry
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// Read one entry, hold the data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/gha_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_engine
// Accepts one transaction and reads a slot; a successful create or release
// then writes a slot back and updates the free-list head or fresh-slot count.
// ----------------------------------------------------------------------------
module gha_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  gha_pkg::req_t     req,
	input  logic              rsp_ready,
	output logic              rsp_load,
	output gha_pkg::rsp_t     rsp_next
);
	import gha_pkg::*;

	logic     s1_valid_s1;
	req_t     item_s1;
	index_t   free_head_q;
	index_t   created_q;
	logic     accept;
	index_t   rd_addr;
	slot_t    rd_data;
	slot_wr_t wr;
	logic     in_range;
	index_t   head_next;
	index_t   created_next;

	assign req_stall = s1_valid_s1;
	assign accept    = req_valid && !s1_valid_s1;
	assign rsp_load  = s1_valid_s1 && rsp_ready;

	// Read the free-list head for create, the given slot otherwise
	assign rd_addr = (req.operation == OP_CREATE) ? free_head_q : req.entity_index;

	gha_slot_ram u_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (wr)
	);

	// Hold the transaction while its slot is read and the result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (rsp_load) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
		end
	end

	assign in_range = item_s1.entity_index < created_q;

	// Modify the slot and compute the result
	always_comb begin
		wr           = '0;
		rsp_next     = '0;
		head_next    = free_head_q;
		created_next = created_q;
		case (item_s1.operation)
			OP_CREATE: begin
				if (free_head_q != NULL_INDEX) begin
					rsp_next.result_index   = free_head_q;
					rsp_next.result_version = rd_data.ver;
					head_next               = rd_data.idx;
					wr.en                   = 1'b1;
					wr.addr                 = free_head_q;
					wr.data.idx             = free_head_q;
					wr.data.ver             = rd_data.ver;
				end else if (created_q != NULL_INDEX) begin
					rsp_next.result_index = created_q;
					wr.en                 = 1'b1;
					wr.addr               = created_q;
					wr.data.idx           = created_q;
					wr.data.ver           = '0;
					created_next          = created_q + index_t'(1);
				end else begin
					rsp_next.status = ST_FULL;
				end
			end
			OP_RELEASE: begin
				if (in_range) begin
					wr.en       = 1'b1;
					wr.addr     = item_s1.entity_index;
					wr.data.idx = free_head_q;
					wr.data.ver = item_s1.entity_version + version_t'(1);
					head_next   = item_s1.entity_index;
				end else begin
					rsp_next.status = ST_NEVER_CREATED;
				end
			end
			OP_VALIDATE: begin
				rsp_next.is_valid = in_range && (rd_data.idx == item_s1.entity_index)
					&& (rd_data.ver == item_s1.entity_version);
			end
			default: begin
				rsp_next = '0;
			end
		endcase
		// Commit only when the result is handed over
		if (!rsp_load) begin
			wr.en        = 1'b0;
			head_next    = free_head_q;
			created_next = created_q;
		end
	end

	// Advance free-list head and fresh-slot count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= NULL_INDEX;
			created_q   <= '0;
		end else begin
			free_head_q <= head_next;
			created_q   <= created_next;
		end
	end

endmodule

### hw/rtl/gha_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gha_out_reg
// Result register: holds one finished transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module gha_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  gha_pkg::rsp_t data_in,
	output logic          ready,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output gha_pkg::rsp_t rsp
);
	import gha_pkg::*;

	logic rsp_valid_q;
	rsp_t rsp_q;

	assign ready     = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Hold until taken, refill on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= data_in;
		end
	end

endmodule

### hw/rtl/generational_handle_allocator.sv
`timescale 1ns / 1ps
// Order: a result is shown once its slot table read is registered and the
// result register has loaded it; the result register loads only when free.
// Flow: a new request is accepted only once the last result is loaded, which
// also commits the write-back; a stalled result register holds the engine.
// Reset: free-list head goes to the null index and the fresh-slot count to 0;
// the slot table is not cleared; read data is used only from written entries.
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Versioned handle allocator with a free list threaded through the slots.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  gha_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output gha_pkg::rsp_t rsp
);
	import gha_pkg::*;

	logic rsp_ready;
	logic rsp_load;
	rsp_t rsp_next;

	gha_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_ready (rsp_ready),
		.rsp_load  (rsp_load),
		.rsp_next  (rsp_next)
	);

	gha_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (rsp_load),
		.data_in   (rsp_next),
		.ready     (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
